// ===== sv/fpec_pkg.sv =====
package fpec_pkg;

    // Corner coordinates are held in units of 2^-26 (Q12.12 scaled by 2^14).
    localparam int FRAC_SHIFT   = 14;
    localparam int POS_W        = 24;
    localparam int DIR_W        = 16;
    localparam int SIZE_W       = 22;
    localparam int PROD_W       = 38;
    localparam int CORNER_W     = 41;
    localparam int TERM_W       = CORNER_W + 1;
    localparam int SUM_W        = TERM_W + 3;
    localparam int OVER_W       = 28;
    localparam int NUM_CORNERS  = 4;
    localparam int NUM_TERMS    = 2 * NUM_CORNERS;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 24;

    localparam logic [OVER_W-1:0] OVERHANG_MAX = '1;

    // Corner order: front-left, front-right, rear-left, rear-right.
    localparam logic [NUM_CORNERS-1:0] CORNER_FRONT = 4'b0011;
    localparam logic [NUM_CORNERS-1:0] CORNER_RIGHT = 4'b1010;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TABLE_MIN_X = 3'd0,
        CFG_TABLE_MAX_X = 3'd1,
        CFG_TABLE_MIN_Z = 3'd2,
        CFG_TABLE_MAX_Z = 3'd3,
        CFG_SAFE_MARGIN = 3'd4,
        CFG_HALF_LENGTH = 3'd5,
        CFG_HALF_WIDTH  = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_z;
        logic signed [DIR_W-1:0] fwd_x;
        logic signed [DIR_W-1:0] fwd_z;
        logic signed [DIR_W-1:0] right_x;
        logic signed [DIR_W-1:0] right_z;
    } t_in_item;

    typedef struct packed {
        logic              cliff_front_left;
        logic              cliff_front_right;
        logic              cliff_rear_left;
        logic              cliff_rear_right;
        logic              all_safe;
        logic [OVER_W-1:0] overhang_total;
    } t_out_item;

    typedef struct packed {
        logic signed [POS_W-1:0] table_min_x;
        logic signed [POS_W-1:0] table_max_x;
        logic signed [POS_W-1:0] table_min_z;
        logic signed [POS_W-1:0] table_max_z;
        logic [SIZE_W-1:0]       safe_margin;
        logic [SIZE_W-1:0]       half_length;
        logic [SIZE_W-1:0]       half_width;
    } t_cfg;

    // Per-stage load enables of the pipeline.
    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } t_adv;

    typedef logic signed [CORNER_W-1:0] t_coord;
    typedef logic [TERM_W-1:0]          t_term;

endpackage

// ===== sv/fpec_cfg.sv =====
module fpec_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [fpec_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [fpec_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output fpec_pkg::t_cfg                      o_cfg
);
    import fpec_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.table_min_x <= -POS_W'(8192);
            r_cfg.table_max_x <= POS_W'(8192);
            r_cfg.table_min_z <= -POS_W'(8192);
            r_cfg.table_max_z <= POS_W'(8192);
            r_cfg.safe_margin <= '0;
            r_cfg.half_length <= SIZE_W'(1024);
            r_cfg.half_width  <= SIZE_W'(512);
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_TABLE_MIN_X: r_cfg.table_min_x <= i_cfg_data;
                CFG_TABLE_MAX_X: r_cfg.table_max_x <= i_cfg_data;
                CFG_TABLE_MIN_Z: r_cfg.table_min_z <= i_cfg_data;
                CFG_TABLE_MAX_Z: r_cfg.table_max_z <= i_cfg_data;
                CFG_SAFE_MARGIN: r_cfg.safe_margin <= i_cfg_data[SIZE_W-1:0];
                CFG_HALF_LENGTH: r_cfg.half_length <= i_cfg_data[SIZE_W-1:0];
                CFG_HALF_WIDTH:  r_cfg.half_width  <= i_cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== sv/fpec_geom.sv =====
module fpec_geom (
    input  logic                    i_clk,
    input  fpec_pkg::t_adv          i_adv,
    input  fpec_pkg::t_in_item      i_item,
    input  fpec_pkg::t_cfg          i_cfg,
    output fpec_pkg::t_coord        o_cx [fpec_pkg::NUM_CORNERS],
    output fpec_pkg::t_coord        o_cz [fpec_pkg::NUM_CORNERS]
);
    import fpec_pkg::*;

    logic signed [PROD_W-1:0] r_lfx, r_lfz, r_wrx, r_wrz;
    logic signed [PROD_W-1:0] n_lfx, n_lfz, n_wrx, n_wrz;
    logic signed [PROD_W-1:0] hl_ext, hw_ext;
    t_coord r_px, r_pz, n_px, n_pz;
    t_coord r_cx [NUM_CORNERS];
    t_coord r_cz [NUM_CORNERS];
    t_coord n_cx [NUM_CORNERS];
    t_coord n_cz [NUM_CORNERS];

    // Stage 2: the four half-size products and the scaled centre.
    always_comb begin
        hl_ext = $signed(PROD_W'(i_cfg.half_length));
        hw_ext = $signed(PROD_W'(i_cfg.half_width));
        n_lfx  = PROD_W'(i_item.fwd_x) * hl_ext;
        n_lfz  = PROD_W'(i_item.fwd_z) * hl_ext;
        n_wrx  = PROD_W'(i_item.right_x) * hw_ext;
        n_wrz  = PROD_W'(i_item.right_z) * hw_ext;
        n_px   = CORNER_W'($signed({i_item.pos_x, FRAC_SHIFT'(0)}));
        n_pz   = CORNER_W'($signed({i_item.pos_z, FRAC_SHIFT'(0)}));
    end

    always_ff @(posedge i_clk) begin
        if (i_adv.s2) begin
            r_lfx <= n_lfx;
            r_lfz <= n_lfz;
            r_wrx <= n_wrx;
            r_wrz <= n_wrz;
            r_px  <= n_px;
            r_pz  <= n_pz;
        end
    end

    // Stage 3: corners as centre +/- length term +/- width term.
    always_comb begin
        for (int k = 0; k < NUM_CORNERS; k++) begin
            n_cx[k] = r_px
                    + (CORNER_FRONT[k] ? CORNER_W'(r_lfx) : -CORNER_W'(r_lfx))
                    + (CORNER_RIGHT[k] ? CORNER_W'(r_wrx) : -CORNER_W'(r_wrx));
            n_cz[k] = r_pz
                    + (CORNER_FRONT[k] ? CORNER_W'(r_lfz) : -CORNER_W'(r_lfz))
                    + (CORNER_RIGHT[k] ? CORNER_W'(r_wrz) : -CORNER_W'(r_wrz));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv.s3) begin
            r_cx <= n_cx;
            r_cz <= n_cz;
        end
    end

    assign o_cx = r_cx;
    assign o_cz = r_cz;

endmodule

// ===== sv/fpec_judge.sv =====
module fpec_judge (
    input  logic                    i_clk,
    input  fpec_pkg::t_adv          i_adv,
    input  fpec_pkg::t_cfg          i_cfg,
    input  fpec_pkg::t_coord        i_cx [fpec_pkg::NUM_CORNERS],
    input  fpec_pkg::t_coord        i_cz [fpec_pkg::NUM_CORNERS],
    output fpec_pkg::t_out_item     o_item
);
    import fpec_pkg::*;

    t_coord min_x, max_x, min_z, max_z, margin;
    t_coord smin_x, smax_x, smin_z, smax_z;
    logic [NUM_CORNERS-1:0] n_cliff, r_cliff, in_safe;
    logic r_safe;
    t_term n_term [NUM_TERMS];
    t_term r_term [NUM_TERMS];
    logic [SUM_W-1:0]          sum;
    logic [SUM_W-FRAC_SHIFT:0] rounded;
    t_out_item n_item, r_item;

    function automatic t_term axis_over(input t_coord c, input t_coord lo, input t_coord hi);
        t_term d;
        begin
            d = '0;
            if (c < lo) begin
                d = TERM_W'(lo) - TERM_W'(c);
            end else if (c > hi) begin
                d = TERM_W'(c) - TERM_W'(hi);
            end
            return d;
        end
    endfunction

    // Stage 4: bound tests and per-axis overhang of every corner.
    always_comb begin
        min_x  = CORNER_W'($signed({i_cfg.table_min_x, FRAC_SHIFT'(0)}));
        max_x  = CORNER_W'($signed({i_cfg.table_max_x, FRAC_SHIFT'(0)}));
        min_z  = CORNER_W'($signed({i_cfg.table_min_z, FRAC_SHIFT'(0)}));
        max_z  = CORNER_W'($signed({i_cfg.table_max_z, FRAC_SHIFT'(0)}));
        margin = CORNER_W'({i_cfg.safe_margin, FRAC_SHIFT'(0)});
        smin_x = min_x + margin;
        smax_x = max_x - margin;
        smin_z = min_z + margin;
        smax_z = max_z - margin;
        for (int k = 0; k < NUM_CORNERS; k++) begin
            n_cliff[k] = !(i_cx[k] >= min_x && i_cx[k] <= max_x &&
                           i_cz[k] >= min_z && i_cz[k] <= max_z);
            in_safe[k] = i_cx[k] >= smin_x && i_cx[k] <= smax_x &&
                         i_cz[k] >= smin_z && i_cz[k] <= smax_z;
            n_term[2*k]   = axis_over(i_cx[k], min_x, max_x);
            n_term[2*k+1] = axis_over(i_cz[k], min_z, max_z);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv.s4) begin
            r_cliff <= n_cliff;
            r_safe  <= &in_safe;
            r_term  <= n_term;
        end
    end

    // Stage 5: sum, round to Q16.12 with ties up, then saturate.
    always_comb begin
        sum = '0;
        for (int t = 0; t < NUM_TERMS; t++) begin
            sum = sum + SUM_W'(r_term[t]);
        end
        rounded = (SUM_W - FRAC_SHIFT + 1)'(
                  ((SUM_W + 1)'(sum) + (SUM_W + 1)'(1 << (FRAC_SHIFT - 1))) >> FRAC_SHIFT);
        n_item.cliff_front_left  = r_cliff[0];
        n_item.cliff_front_right = r_cliff[1];
        n_item.cliff_rear_left   = r_cliff[2];
        n_item.cliff_rear_right  = r_cliff[3];
        n_item.all_safe          = r_safe;
        if (rounded > (SUM_W - FRAC_SHIFT + 1)'(OVERHANG_MAX)) begin
            n_item.overhang_total = OVERHANG_MAX;
        end else begin
            n_item.overhang_total = rounded[OVER_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv.s5) begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;

endmodule

// ===== sv/footprint_table_edge_check_top.sv =====
// Each accepted item passes through the five-stage register pipeline
// (input, products, corners, bound tests, overhang sum) and is then offered;
// one item per cycle is taken while the output is not stalled.
// A stalled output holds its result; empty stages still fill behind it.
// Reset (i_rst_n low, synchronous) empties the pipeline and loads the
// register defaults; configuration writes are always ready.
module footprint_table_edge_check_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  fpec_pkg::t_in_item                  i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output fpec_pkg::t_out_item                 o_out,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [fpec_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [fpec_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import fpec_pkg::*;

    t_cfg     cfg;
    t_adv     adv;
    t_in_item r_in;
    logic     adv_s1;
    logic     r_v1, r_v2, r_v3, r_v4, r_v5;
    t_coord   cx [NUM_CORNERS];
    t_coord   cz [NUM_CORNERS];

    // A stage loads when it is empty or its content moves on.
    always_comb begin
        adv.s5 = !r_v5 || !i_out_stall;
        adv.s4 = !r_v4 || adv.s5;
        adv.s3 = !r_v3 || adv.s4;
        adv.s2 = !r_v2 || adv.s3;
        adv_s1 = !r_v1 || adv.s2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (adv_s1) begin
                r_v1 <= i_in_valid;
            end
            if (adv.s2) begin
                r_v2 <= r_v1;
            end
            if (adv.s3) begin
                r_v3 <= r_v2;
            end
            if (adv.s4) begin
                r_v4 <= r_v3;
            end
            if (adv.s5) begin
                r_v5 <= r_v4;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_s1) begin
            r_in <= i_in;
        end
    end

    fpec_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    fpec_geom u_geom (
        .i_clk  (i_clk),
        .i_adv  (adv),
        .i_item (r_in),
        .i_cfg  (cfg),
        .o_cx   (cx),
        .o_cz   (cz)
    );

    fpec_judge u_judge (
        .i_clk  (i_clk),
        .i_adv  (adv),
        .i_cfg  (cfg),
        .i_cx   (cx),
        .i_cz   (cz),
        .o_item (o_out)
    );

    assign o_in_stall  = !adv_s1;
    assign o_out_valid = r_v5;
    assign o_cfg_ready = 1'b1;

endmodule

// ===== sv/fpec_checker.sv =====
module fpec_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                o_in_stall,
    input  logic                                o_out_valid,
    input  logic                                i_out_stall,
    input  fpec_pkg::t_out_item                 o_out
);
    import fpec_pkg::*;

    // A result that is not taken stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // Reset leaves no result behind.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered after reset");

    // The input side only backs up when a finished result is held.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled with room in the pipeline");

    // All corners inside the shrunk rectangle means none is off the table.
    a_safe_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.all_safe |->
            !o_out.cliff_front_left && !o_out.cliff_front_right &&
            !o_out.cliff_rear_left && !o_out.cliff_rear_right &&
            o_out.overhang_total == '0)
        else $error("safe result with overhang");

endmodule

bind footprint_table_edge_check_top fpec_checker u_fpec_checker (.*);

// ===== tb/footprint_checker.sv =====
`timescale 1ns / 1ps

module footprint_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_in_stall,
    input  fpec_pkg::t_in_item                i_in,
    input  logic                              i_out_valid,
    input  logic                              i_out_stall,
    input  fpec_pkg::t_out_item               i_out,
    input  logic                              i_cfg_valid,
    input  logic                              i_cfg_ready,
    input  logic [fpec_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [fpec_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output int                                o_pending,
    output int                                o_fail_count
);
    import fpec_pkg::*;

    t_cfg      table_regs;
    t_out_item footprint_queue[$];
    int        n_fail = 0;

    initial begin
        o_pending = 0;
        o_fail_count = 0;
    end

    function automatic longint overhang_1d(longint c, longint lo, longint hi);
        if (c < lo) begin
            return lo - c;
        end
        if (c > hi) begin
            return c - hi;
        end
        return 0;
    endfunction

    // All coordinates are carried in units of 2^-26, so every test is exact.
    function automatic t_out_item predict_footprint(t_in_item it, t_cfg c);
        longint px, pz, fx, fz, rx, rz, hl, hw;
        longint lfx, lfz, wrx, wrz, cx, cz;
        longint minx, maxx, minz, maxz, m, over;
        logic [3:0] off;
        logic safe;
        logic front, right;
        t_out_item r;
        int k;
        px = longint'($signed(it.pos_x)) <<< FRAC_SHIFT;
        pz = longint'($signed(it.pos_z)) <<< FRAC_SHIFT;
        fx = longint'($signed(it.fwd_x));
        fz = longint'($signed(it.fwd_z));
        rx = longint'($signed(it.right_x));
        rz = longint'($signed(it.right_z));
        hl = longint'(c.half_length);
        hw = longint'(c.half_width);
        minx = longint'($signed(c.table_min_x)) <<< FRAC_SHIFT;
        maxx = longint'($signed(c.table_max_x)) <<< FRAC_SHIFT;
        minz = longint'($signed(c.table_min_z)) <<< FRAC_SHIFT;
        maxz = longint'($signed(c.table_max_z)) <<< FRAC_SHIFT;
        m = longint'(c.safe_margin) <<< FRAC_SHIFT;
        lfx = fx * hl;
        lfz = fz * hl;
        wrx = rx * hw;
        wrz = rz * hw;
        safe = 1'b1;
        over = 0;
        // Corner k: 0 front-left, 1 front-right, 2 rear-left, 3 rear-right.
        for (k = 0; k < 4; k++) begin
            front = (k < 2);
            right = k[0];
            cx = px + (front ? lfx : -lfx) + (right ? wrx : -wrx);
            cz = pz + (front ? lfz : -lfz) + (right ? wrz : -wrz);
            off[k] = !(cx >= minx && cx <= maxx && cz >= minz && cz <= maxz);
            if (!(cx >= minx + m && cx <= maxx - m && cz >= minz + m && cz <= maxz - m)) begin
                safe = 1'b0;
            end
            over += overhang_1d(cx, minx, maxx);
            over += overhang_1d(cz, minz, maxz);
        end
        over = (over + (longint'(1) <<< (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
        if (over > longint'(OVERHANG_MAX)) begin
            over = longint'(OVERHANG_MAX);
        end
        r.cliff_front_left  = off[0];
        r.cliff_front_right = off[1];
        r.cliff_rear_left   = off[2];
        r.cliff_rear_right  = off[3];
        r.all_safe          = safe;
        r.overhang_total    = over[OVER_W-1:0];
        return r;
    endfunction

    task automatic check_field(string name, longint unsigned want_v, longint unsigned got_v);
        if (want_v != got_v) begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            n_fail++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            table_regs.table_min_x = POS_W'(-8192);
            table_regs.table_max_x = POS_W'(8192);
            table_regs.table_min_z = POS_W'(-8192);
            table_regs.table_max_z = POS_W'(8192);
            table_regs.safe_margin = '0;
            table_regs.half_length = SIZE_W'(1024);
            table_regs.half_width  = SIZE_W'(512);
            footprint_queue.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_TABLE_MIN_X: table_regs.table_min_x = i_cfg_data;
                    CFG_TABLE_MAX_X: table_regs.table_max_x = i_cfg_data;
                    CFG_TABLE_MIN_Z: table_regs.table_min_z = i_cfg_data;
                    CFG_TABLE_MAX_Z: table_regs.table_max_z = i_cfg_data;
                    CFG_SAFE_MARGIN: table_regs.safe_margin = i_cfg_data[SIZE_W-1:0];
                    CFG_HALF_LENGTH: table_regs.half_length = i_cfg_data[SIZE_W-1:0];
                    CFG_HALF_WIDTH:  table_regs.half_width  = i_cfg_data[SIZE_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (footprint_queue.size() == 0) begin
                    $error("result with no item pending: overhang_total %0d",
                           i_out.overhang_total);
                    n_fail++;
                end else begin
                    want = footprint_queue.pop_front();
                    check_field("cliff_front_left", want.cliff_front_left,
                                i_out.cliff_front_left);
                    check_field("cliff_front_right", want.cliff_front_right,
                                i_out.cliff_front_right);
                    check_field("cliff_rear_left", want.cliff_rear_left,
                                i_out.cliff_rear_left);
                    check_field("cliff_rear_right", want.cliff_rear_right,
                                i_out.cliff_rear_right);
                    check_field("all_safe", want.all_safe, i_out.all_safe);
                    check_field("overhang_total", want.overhang_total,
                                i_out.overhang_total);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                footprint_queue.push_back(predict_footprint(i_in, table_regs));
            end
        end
        o_pending <= footprint_queue.size();
        o_fail_count <= n_fail;
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import fpec_pkg::*;

    localparam time    HALF_PERIOD = 5ns;
    localparam longint CYCLE_LIMIT = 200000;
    localparam longint POS_LO      = -8388608;
    localparam longint POS_HI      = 8388607;
    localparam longint SIZE_HI     = 4194303;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    t_in_item              i_in        = '0;
    logic                  i_out_stall = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    logic                  o_cfg_ready;
    t_out_item             o_out;

    int     results_pending;
    int     fail_count;
    bit     steady = 1'b0;
    int     out_hold = 0;
    longint cycle_count = 0;

    // Table settings as last written, used to aim the poses.
    longint tb_min_x = -8192;
    longint tb_max_x = 8192;
    longint tb_min_z = -8192;
    longint tb_max_z = 8192;
    longint tb_margin = 0;
    longint tb_half_len = 1024;
    longint tb_half_wid = 512;

    footprint_table_edge_check_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    footprint_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in         (i_in),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out        (o_out),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_pending    (results_pending),
        .o_fail_count (fail_count)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[footprint_table_edge_check_top] ERROR");
            $finish;
        end
    end

    // Receiver: after each accepted result, hold stall for a random count.
    always @(posedge i_clk) begin
        int hold;
        if (o_out_valid && !i_out_stall) begin
            hold = steady ? 0 : $urandom_range(0, 6);
            out_hold <= hold;
            i_out_stall <= (hold != 0);
        end else if (out_hold > 0) begin
            out_hold <= out_hold - 1;
            i_out_stall <= (out_hold > 1);
        end
    end

    function automatic longint clamp_pos(longint v);
        if (v < POS_LO) begin
            return POS_LO;
        end
        if (v > POS_HI) begin
            return POS_HI;
        end
        return v;
    endfunction

    function automatic t_in_item make_pose(longint px, longint pz, longint fx, longint fz,
                                           longint rx, longint rz);
        t_in_item it;
        it.pos_x   = px[POS_W-1:0];
        it.pos_z   = pz[POS_W-1:0];
        it.fwd_x   = fx[DIR_W-1:0];
        it.fwd_z   = fz[DIR_W-1:0];
        it.right_x = rx[DIR_W-1:0];
        it.right_z = rz[DIR_W-1:0];
        return it;
    endfunction

    // Mostly plausible poses around the table, some aimed exactly at the
    // table or margin edges, and a share of fully random bit patterns.
    function automatic t_in_item random_pose();
        t_in_item it;
        logic [127:0] raw;
        longint reach, lo_x, hi_x, lo_z, hi_z, px, pz, fx, fz, rx, rz, s, inset;
        int pick;
        pick = $urandom_range(0, 99);
        reach = tb_half_len + tb_half_wid + 4096;
        lo_x = clamp_pos(((tb_min_x < tb_max_x) ? tb_min_x : tb_max_x) - reach);
        hi_x = clamp_pos(((tb_min_x < tb_max_x) ? tb_max_x : tb_min_x) + reach);
        lo_z = clamp_pos(((tb_min_z < tb_max_z) ? tb_min_z : tb_max_z) - reach);
        hi_z = clamp_pos(((tb_min_z < tb_max_z) ? tb_max_z : tb_min_z) + reach);
        px = lo_x + longint'($urandom) % (hi_x - lo_x + 1);
        pz = lo_z + longint'($urandom) % (hi_z - lo_z + 1);
        if (pick < 15) begin
            raw = {$urandom, $urandom, $urandom, $urandom};
            it = raw[$bits(t_in_item)-1:0];
        end else if (pick < 70) begin
            fx = longint'($urandom_range(0, 32768)) - 16384;
            fz = longint'($rtoi($sqrt(real'(268435456 - fx * fx))));
            if ($urandom_range(0, 1) == 1) begin
                fz = -fz;
            end
            s = ($urandom_range(0, 1) == 1) ? 1 : -1;
            it = make_pose(px, pz, fx, fz, -s * fz, s * fx);
        end else if (pick < 85) begin
            s = ($urandom_range(0, 1) == 1) ? 1 : -1;
            inset = ($urandom_range(0, 1) == 1) ? tb_margin : 0;
            if ($urandom_range(0, 1) == 1) begin
                px = tb_max_x - inset - tb_half_len + $urandom_range(0, 2) - 1;
            end else begin
                px = tb_min_x + inset + tb_half_len + $urandom_range(0, 2) - 1;
            end
            if ($urandom_range(0, 1) == 1) begin
                pz = tb_max_z - inset - tb_half_wid + $urandom_range(0, 2) - 1;
            end else begin
                pz = tb_min_z + inset + tb_half_wid + $urandom_range(0, 2) - 1;
            end
            it = make_pose(clamp_pos(px), clamp_pos(pz), s * 16384, 0, 0, s * 16384);
        end else begin
            fx = longint'($urandom_range(0, 32768)) - 16384;
            fz = longint'($urandom_range(0, 32768)) - 16384;
            rx = longint'($urandom_range(0, 32768)) - 16384;
            rz = longint'($urandom_range(0, 32768)) - 16384;
            it = make_pose(px, pz, fx, fz, rx, rz);
        end
        return it;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value[CFG_DATA_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // The size registers get junk in the data bits above their width.
    task automatic load_table(longint min_x, longint max_x, longint min_z, longint max_z,
                              longint margin, longint half_len, longint half_wid);
        write_reg(CFG_TABLE_MIN_X, min_x);
        write_reg(CFG_TABLE_MAX_X, max_x);
        write_reg(CFG_TABLE_MIN_Z, min_z);
        write_reg(CFG_TABLE_MAX_Z, max_z);
        write_reg(CFG_SAFE_MARGIN, margin | (longint'($urandom_range(0, 3)) << SIZE_W));
        write_reg(CFG_HALF_LENGTH, half_len | (longint'($urandom_range(0, 3)) << SIZE_W));
        write_reg(CFG_HALF_WIDTH, half_wid | (longint'($urandom_range(0, 3)) << SIZE_W));
        tb_min_x = min_x;
        tb_max_x = max_x;
        tb_min_z = min_z;
        tb_max_z = max_z;
        tb_margin = margin;
        tb_half_len = half_len;
        tb_half_wid = half_wid;
    endtask

    // Called at the clock edge where the last item was taken.
    task automatic send_pose(t_in_item it);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 6);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in <= it;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (results_pending != 0);
    endtask

    task automatic run_poses(int count);
        int n;
        for (n = 0; n < count; n++) begin
            if (n % 64 == 0) begin
                steady <= ($urandom_range(0, 3) == 0);
            end
            send_pose(random_pose());
        end
        steady <= 1'b0;
    endtask

    initial begin
        longint centre_x, centre_z, span_x, span_z;
        int p;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: a 4 by 4 table with a small body.
        send_pose(make_pose(0, 0, 16384, 0, 0, 16384));
        send_pose(make_pose(7168, 0, 16384, 0, 0, 16384));
        send_pose(make_pose(7169, 0, 16384, 0, 0, 16384));
        send_pose(make_pose(-7168, 0, 16384, 0, 0, -16384));
        send_pose(make_pose(-7169, 0, 16384, 0, 0, -16384));
        send_pose(make_pose(0, 7680, 16384, 0, 0, 16384));
        send_pose(make_pose(0, 7681, 16384, 0, 0, 16384));
        send_pose(make_pose(0, -7680, 0, -16384, 16384, 0));
        send_pose(make_pose(POS_HI, POS_HI, -16384, 16384, 16384, -16384));
        send_pose(make_pose(POS_LO, POS_LO, 16384, -16384, -16384, 16384));
        send_pose(make_pose(POS_HI, POS_LO, 32767, -32768, -32768, 32767));
        send_pose(make_pose(0, 0, 0, 0, 0, 0));
        send_pose(make_pose(8192, -8192, 0, 0, 0, 0));
        send_pose(make_pose(7000, 7000, 11585, 11585, 11585, -11585));
        send_pose(make_pose(-7700, 7700, -11585, 11585, 11585, 11585));
        run_poses(150);
        drain_results();
        run_poses(150);
        drain_results();

        // Widest table, largest margin and body.
        load_table(POS_LO, POS_HI, POS_LO, POS_HI, SIZE_HI, SIZE_HI, SIZE_HI);
        send_pose(make_pose(0, 0, 16384, 0, 0, 16384));
        send_pose(make_pose(POS_HI, POS_HI, 32767, 32767, 32767, -32768));
        run_poses(80);
        drain_results();

        // Fully inverted bounds with a point body; a write past the last register.
        load_table(POS_HI, POS_LO, POS_HI, POS_LO, 0, 0, 0);
        write_reg(CFG_IDX_SPARE, longint'($urandom));
        send_pose(make_pose(POS_LO, POS_LO, 16384, 0, 0, 16384));
        send_pose(make_pose(POS_HI, POS_HI, -32768, 32767, 32767, -32768));
        run_poses(80);
        drain_results();

        // Moderately inverted bounds.
        load_table(4096, -4096, 2048, -6144, 1024, 2048, 1536);
        run_poses(80);
        drain_results();

        // Margin wider than half the table leaves no safe area.
        load_table(-8192, 8192, -8192, 8192, 9000, 1024, 512);
        run_poses(80);
        drain_results();

        // Single-point table in the far corner: the largest overhang.
        load_table(POS_LO, POS_LO, POS_LO, POS_LO, 0, SIZE_HI, SIZE_HI);
        send_pose(make_pose(POS_HI, POS_HI, -32768, -32768, -32768, 32767));
        send_pose(make_pose(POS_LO, POS_LO, 0, 0, 0, 0));
        run_poses(80);
        drain_results();

        for (p = 0; p < 6; p++) begin
            centre_x = longint'($urandom_range(0, 1 << 21)) - (1 << 20);
            centre_z = longint'($urandom_range(0, 1 << 21)) - (1 << 20);
            span_x = $urandom_range(0, 1 << 18);
            span_z = $urandom_range(0, 1 << 18);
            if ($urandom_range(0, 4) == 0) begin
                span_x = -span_x;
            end
            if (p == 2) begin
                write_reg(CFG_IDX_SPARE, longint'($urandom));
            end
            load_table(centre_x - span_x, centre_x + span_x, centre_z - span_z,
                       centre_z + span_z, $urandom_range(0, 1 << 18),
                       $urandom_range(0, 1 << 17), $urandom_range(0, 1 << 17));
            run_poses(75);
            drain_results();
        end

        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && results_pending == 0) begin
            $display("[footprint_table_edge_check_top] OK");
        end else begin
            $display("[footprint_table_edge_check_top] ERROR");
        end
        $finish;
    end

endmodule
